@@ rtl/core/evf_pkg.sv @@
package evf_pkg;

  localparam int NUM_FLAGS    = 64;
  localparam int WAITERS      = 16;
  localparam int PATTERN_BITS = 32;

  // Pattern width that is kept in the tables; the command field is 32 bits wide.
  localparam int PAT_W      = (PATTERN_BITS < 32) ? PATTERN_BITS : 32;
  localparam int FLAG_IDX_W = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;
  localparam int WIDX_W     = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int CNT_W      = $clog2(WAITERS + 1);

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_SET    = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_WAIT   = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    STAT_OK         = 4'd0,
    STAT_BAD_PARAM  = 4'd1,
    STAT_NO_ID      = 4'd2,
    STAT_NO_FLAG    = 4'd3,
    STAT_BUSY       = 4'd4,
    STAT_QUEUED     = 4'd5,
    STAT_FULL       = 4'd6,
    STAT_RELEASED   = 4'd7,
    STAT_DELETED    = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_CSCAN,
    S_SCAN,
    S_WSCAN,
    S_WCHK
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  flag_id;
    logic [31:0] pattern;
    logic        wait_or;
    logic        wait_clear;
    logic        single_waiter;
    logic [7:0]  task_id;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  flag_id_out;
    logic [31:0] pattern_out;
    logic [7:0]  task_id_out;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [5:0]       flag;
    logic [PAT_W-1:0] pattern;
    logic             any;
    logic             clears;
    logic [7:0]       task_id;
  } waiter_t;

  function automatic logic pat_match(logic [PAT_W-1:0] bits, logic [PAT_W-1:0] want,
                                     logic any);
    if (any) begin
      return (bits & want) != '0;
    end
    return (bits & want) == want;
  endfunction

endpackage

@@ rtl/core/event_flag_unit.sv @@
// Event-flag manager. A command is taken when start is high and busy is low; its
// results come out on rsp_o, at most one record per cycle, each marked by
// rsp_valid_o for a single cycle, and the final record of a command has last set.
// The receiver cannot hold records off. Timing is set by a sequencer that walks
// one table entry per cycle: create scans flag ids from zero, one per cycle, until
// it finds a free one or reaches the last id; set and delete walk every queued
// waiter; wait walks the queued waiters only on a single-waiter flag; clear and
// rejected commands walk none. Flag patterns sit in a RAM with a registered read.
module event_flag_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  evf_pkg::cmd_t cmd_i,
  output logic          rsp_valid_o,
  output evf_pkg::rsp_t rsp_o
);

  import evf_pkg::*;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [PAT_W-1:0] bits_q, bits_d;
  logic [CNT_W-1:0] rd_q, rd_d, wr_q, wr_d, count_q, count_d;
  logic [FLAG_IDX_W-1:0] cidx_q, cidx_d;
  logic [NUM_FLAGS-1:0] exists_q, exists_d, single_q, single_d;
  waiter_t tbl_q [WAITERS];
  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;

  logic [FLAG_IDX_W-1:0] fidx;
  logic [PAT_W-1:0] pat_m;
  logic known, scan_more, cur_hit, rel, wait_hit;
  waiter_t cur;
  logic tbl_we;
  logic [WIDX_W-1:0] tbl_widx;
  waiter_t tbl_wdata;
  logic ram_we;
  logic [FLAG_IDX_W-1:0] ram_waddr;
  logic [PAT_W-1:0] ram_wdata, ram_rdata;

  assign fidx      = FLAG_IDX_W'(cmd_q.flag_id);
  assign pat_m     = PAT_W'(cmd_q.pattern);
  assign known     = (32'(cmd_q.flag_id) < NUM_FLAGS) && exists_q[fidx];
  assign scan_more = rd_q < count_q;
  assign cur       = tbl_q[rd_q[WIDX_W-1:0]];
  assign cur_hit   = scan_more && (cur.flag == cmd_q.flag_id);
  assign rel       = cur_hit && ((cmd_q.mode == MODE_DELETE) ||
                                 pat_match(bits_q, cur.pattern, cur.any));
  assign wait_hit  = pat_match(bits_q, pat_m, cmd_q.wait_or);
  assign busy      = state_q != S_IDLE;

  evf_ram #(
    .Width(PAT_W),
    .Depth(NUM_FLAGS)
  ) u_bits_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(fidx),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (cmd_q.mode == MODE_CREATE) begin
          state_d = S_CSCAN;
        end else if (cmd_q.mode > MODE_WAIT) begin
          state_d = S_IDLE;
        end else if (cmd_q.mode == MODE_WAIT && pat_m == '0) begin
          state_d = S_IDLE;
        end else if (!known) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        priority if (cmd_q.mode == MODE_CLEAR) begin
          state_d = S_IDLE;
        end else if (cmd_q.mode == MODE_WAIT) begin
          state_d = single_q[fidx] ? S_WSCAN : S_WCHK;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_more) begin
          state_d = S_IDLE;
        end
      end
      S_WSCAN: begin
        priority if (cur_hit) begin
          state_d = S_IDLE;
        end else if (!scan_more) begin
          state_d = S_WCHK;
        end else begin
          state_d = S_WSCAN;
        end
      end
      S_WCHK: state_d = S_IDLE;
      S_CSCAN: begin
        if (!exists_q[cidx_q] || 32'(cidx_q) == NUM_FLAGS - 1) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and records.
  always_comb begin
    cmd_d       = cmd_q;
    bits_d      = bits_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    count_d     = count_q;
    cidx_d      = cidx_q;
    exists_d    = exists_q;
    single_d    = single_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    rsp_d.last  = 1'b1;
    tbl_we      = 1'b0;
    tbl_widx    = wr_q[WIDX_W-1:0];
    tbl_wdata   = cur;
    ram_we      = 1'b0;
    ram_waddr   = fidx;
    ram_wdata   = bits_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
        end
      end
      S_DECODE: begin
        rd_d   = '0;
        wr_d   = '0;
        cidx_d = '0;
        priority if (cmd_q.mode == MODE_CREATE) begin
        end else if (cmd_q.mode > MODE_WAIT) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = STAT_BAD_PARAM;
        end else if (cmd_q.mode == MODE_WAIT && pat_m == '0) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STAT_BAD_PARAM;
          rsp_d.task_id_out = cmd_q.task_id;
        end else if (!known) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = STAT_NO_FLAG;
          if (cmd_q.mode == MODE_WAIT) begin
            rsp_d.task_id_out = cmd_q.task_id;
          end
        end else begin
        end
      end
      S_LOAD: begin
        bits_d = ram_rdata;
        if (cmd_q.mode == MODE_SET) begin
          bits_d = ram_rdata | pat_m;
        end
        if (cmd_q.mode == MODE_CLEAR) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata & pat_m;
          rsp_valid_d  = 1'b1;
          rsp_d.status = STAT_OK;
        end
      end
      S_SCAN: begin
        if (scan_more) begin
          rd_d = rd_q + 1'b1;
          if (rel) begin
            rsp_valid_d       = 1'b1;
            rsp_d.last        = 1'b0;
            rsp_d.task_id_out = cur.task_id;
            if (cmd_q.mode == MODE_DELETE) begin
              rsp_d.status = STAT_DELETED;
            end else begin
              rsp_d.status      = STAT_RELEASED;
              rsp_d.pattern_out = 32'(bits_q);
              if (cur.clears) begin
                bits_d = '0;
              end
            end
          end else begin
            // Kept entries slide down over released ones, so order is preserved.
            tbl_we = wr_q != rd_q;
            wr_d   = wr_q + 1'b1;
          end
        end else begin
          count_d      = wr_q;
          rsp_valid_d  = 1'b1;
          rsp_d.status = STAT_OK;
          if (cmd_q.mode == MODE_SET) begin
            ram_we = 1'b1;
          end else begin
            exists_d[fidx] = 1'b0;
            single_d[fidx] = 1'b0;
          end
        end
      end
      S_WSCAN: begin
        rd_d = rd_q + 1'b1;
        if (cur_hit) begin
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STAT_BUSY;
          rsp_d.task_id_out = cmd_q.task_id;
        end
      end
      S_WCHK: begin
        rsp_valid_d       = 1'b1;
        rsp_d.task_id_out = cmd_q.task_id;
        priority if (wait_hit) begin
          rsp_d.status      = STAT_OK;
          rsp_d.pattern_out = 32'(bits_q);
          if (cmd_q.wait_clear) begin
            ram_we    = 1'b1;
            ram_wdata = '0;
          end
        end else if (32'(count_q) >= WAITERS) begin
          rsp_d.status = STAT_FULL;
        end else begin
          rsp_d.status      = STAT_QUEUED;
          tbl_we            = 1'b1;
          tbl_widx          = count_q[WIDX_W-1:0];
          tbl_wdata.flag    = cmd_q.flag_id;
          tbl_wdata.pattern = pat_m;
          tbl_wdata.any     = cmd_q.wait_or;
          tbl_wdata.clears  = cmd_q.wait_clear;
          tbl_wdata.task_id = cmd_q.task_id;
          count_d           = count_q + 1'b1;
        end
      end
      S_CSCAN: begin
        cidx_d = cidx_q + 1'b1;
        priority if (!exists_q[cidx_q]) begin
          exists_d[cidx_q]  = 1'b1;
          single_d[cidx_q]  = cmd_q.single_waiter;
          ram_we            = 1'b1;
          ram_waddr         = cidx_q;
          ram_wdata         = pat_m;
          rsp_valid_d       = 1'b1;
          rsp_d.status      = STAT_OK;
          rsp_d.flag_id_out = 6'(cidx_q);
        end else if (32'(cidx_q) == NUM_FLAGS - 1) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = STAT_NO_ID;
        end else begin
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      exists_q    <= '0;
      single_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      exists_q    <= exists_d;
      single_q    <= single_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    bits_q <= bits_d;
    rd_q   <= rd_d;
    wr_q   <= wr_d;
    cidx_q <= cidx_d;
    rsp_q  <= rsp_d;
    if (tbl_we) begin
      tbl_q[tbl_widx] <= tbl_wdata;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ rtl/core/evf_ram.sv @@
module evf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ tb/event_flag_unit_tb.sv @@
`timescale 1ns / 100ps

module event_flag_unit_tb;
  import evf_pkg::*;

  localparam int WDOG_LIMIT = 20000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  cmd_t  cmd_i = '0;
  logic  rsp_valid_o;
  rsp_t  rsp_o;

  event_flag_unit i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o(rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the flag and waiter tables.
  logic            fl_live   [NUM_FLAGS];
  logic            fl_single [NUM_FLAGS];
  logic [31:0]     fl_bits   [NUM_FLAGS];
  waiter_t         wq[$];

  cmd_t  cmd_queue[$];
  rsp_t  rsp_expected[$];
  int    send_idle_pct = 16;
  int    mismatches = 0;
  int    wdog = 0;

  function automatic bit is_match(logic [31:0] bits, logic [31:0] want, logic any);
    return any ? ((bits & want) != 0) : ((bits & want) == want);
  endfunction

  function automatic rsp_t mk(status_e st, logic [5:0] fid, logic [31:0] pat,
                              logic [7:0] tsk, logic lst);
    rsp_t r;
    r.status = st; r.flag_id_out = fid; r.pattern_out = pat;
    r.task_id_out = tsk; r.last = lst;
    return r;
  endfunction

  task automatic predict_flag_cmd(cmd_t c);
    int i;
    int f;
    bit found;
    f = c.flag_id;
    if (c.mode > MODE_WAIT) begin
      rsp_expected.push_back(mk(STAT_BAD_PARAM, 0, 0, 0, 1));
    end else if (c.mode == MODE_CREATE) begin
      found = 0;
      for (i = 0; i < NUM_FLAGS && !found; i++) begin
        if (!fl_live[i]) begin
          found = 1;
          fl_live[i] = 1; fl_single[i] = c.single_waiter; fl_bits[i] = c.pattern;
          rsp_expected.push_back(mk(STAT_OK, i[5:0], 0, 0, 1));
        end
      end
      if (!found) rsp_expected.push_back(mk(STAT_NO_ID, 0, 0, 0, 1));
    end else if (c.mode == MODE_WAIT && c.pattern == 0) begin
      rsp_expected.push_back(mk(STAT_BAD_PARAM, 0, 0, c.task_id, 1));
    end else if (!fl_live[f]) begin
      rsp_expected.push_back(mk(STAT_NO_FLAG, 0, 0,
                                c.mode == MODE_WAIT ? c.task_id : 8'd0, 1));
    end else if (c.mode == MODE_DELETE) begin
      i = 0;
      while (i < wq.size()) begin
        if (wq[i].flag == f) begin
          rsp_expected.push_back(mk(STAT_DELETED, 0, 0, wq[i].task_id, 0));
          wq.delete(i);
        end else i++;
      end
      fl_live[f] = 0; fl_single[f] = 0;
      rsp_expected.push_back(mk(STAT_OK, 0, 0, 0, 1));
    end else if (c.mode == MODE_SET) begin
      fl_bits[f] |= c.pattern;
      i = 0;
      while (i < wq.size()) begin
        if (wq[i].flag == f && is_match(fl_bits[f], wq[i].pattern, wq[i].any)) begin
          rsp_expected.push_back(mk(STAT_RELEASED, 0, fl_bits[f], wq[i].task_id, 0));
          if (wq[i].clears) fl_bits[f] = 0;
          wq.delete(i);
        end else i++;
      end
      rsp_expected.push_back(mk(STAT_OK, 0, 0, 0, 1));
    end else if (c.mode == MODE_CLEAR) begin
      fl_bits[f] &= c.pattern;
      rsp_expected.push_back(mk(STAT_OK, 0, 0, 0, 1));
    end else begin
      found = 0;
      if (fl_single[f])
        foreach (wq[j]) if (wq[j].flag == f) found = 1;
      if (found) begin
        rsp_expected.push_back(mk(STAT_BUSY, 0, 0, c.task_id, 1));
      end else if (is_match(fl_bits[f], c.pattern, c.wait_or)) begin
        rsp_expected.push_back(mk(STAT_OK, 0, fl_bits[f], c.task_id, 1));
        if (c.wait_clear) fl_bits[f] = 0;
      end else if (wq.size() >= WAITERS) begin
        rsp_expected.push_back(mk(STAT_FULL, 0, 0, c.task_id, 1));
      end else begin
        wq.push_back('{flag: c.flag_id, pattern: c.pattern, any: c.wait_or,
                       clears: c.wait_clear, task_id: c.task_id});
        rsp_expected.push_back(mk(STAT_QUEUED, 0, 0, c.task_id, 1));
      end
    end
  endtask

  // Driver: start stays high while the item is pending; a transfer happens
  // at an edge with start high and busy low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_flag_cmd(cmd_i);
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_i <= cmd_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start && cmd_queue.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        cmd_i <= cmd_queue.pop_front();
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o || (start && !busy)) wdog <= 0;
      else wdog <= wdog + 1;
      if (rsp_valid_o) begin
        if (rsp_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record %p", rsp_o);
        end else if (rsp_o !== rsp_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch: expected %p actual %p", rsp_expected[0], rsp_o);
          void'(rsp_expected.pop_front());
        end else begin
          void'(rsp_expected.pop_front());
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("event_flag_unit_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic cmd_t rand_cmd(int phase_mode);
    cmd_t c;
    c = '0;
    c.mode = 3'(phase_mode);
    c.flag_id = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(5));
    case ($urandom_range(3))
      0: c.pattern = $urandom;
      1: c.pattern = 32'd1 << $urandom_range(31);
      2: c.pattern = $urandom & 32'h0000_000f;
      default: c.pattern = $urandom & 32'h0000_00ff;
    endcase
    c.wait_or = 1'($urandom);
    c.wait_clear = 1'($urandom);
    c.single_waiter = ($urandom_range(3) == 0);
    c.task_id = 8'($urandom);
    return c;
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 8) return MODE_CREATE;
    if (r < 14) return MODE_DELETE;
    if (r < 40) return MODE_SET;
    if (r < 50) return MODE_CLEAR;
    if (r < 97) return MODE_WAIT;
    return $urandom_range(5, 7);
  endfunction

  task automatic queue_cmd(int m, int fid, logic [31:0] pat, bit w_or, bit w_clr,
                           bit sgl, int tsk);
    cmd_t c;
    c.mode = 3'(m); c.flag_id = 6'(fid); c.pattern = pat; c.wait_or = w_or;
    c.wait_clear = w_clr; c.single_waiter = sgl; c.task_id = 8'(tsk);
    cmd_queue.push_back(c);
  endtask

  task automatic run_random(int n);
    cmd_t c;
    repeat (n) begin
      c = rand_cmd(pick_mode());
      if (c.mode == MODE_CREATE && $urandom_range(1)) c.pattern = 0;
      cmd_queue.push_back(c);
    end
    wait (cmd_queue.size() == 0 && !start);
    wait (rsp_expected.size() == 0);
  endtask

  initial begin
    foreach (fl_live[i]) begin
      fl_live[i] = 0; fl_single[i] = 0; fl_bits[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bad modes, missing flags, creation, all match kinds.
    queue_cmd(7, 0, 32'hffff_ffff, 1, 1, 1, 255);
    queue_cmd(5, 63, 0, 0, 0, 0, 0);
    queue_cmd(MODE_SET, 63, 32'h1, 0, 0, 0, 0);
    queue_cmd(MODE_WAIT, 3, 0, 0, 0, 0, 9);
    queue_cmd(MODE_WAIT, 3, 32'h1, 0, 0, 0, 10);
    queue_cmd(MODE_CREATE, 0, 32'h0, 0, 0, 0, 0);
    queue_cmd(MODE_CREATE, 0, 32'hffff_ffff, 0, 0, 1, 0);
    queue_cmd(MODE_WAIT, 1, 32'h8000_0001, 0, 1, 0, 11);
    queue_cmd(MODE_WAIT, 0, 32'h0000_0003, 0, 0, 0, 12);
    queue_cmd(MODE_WAIT, 0, 32'h0000_0010, 1, 1, 0, 13);
    queue_cmd(MODE_WAIT, 1, 32'h1, 0, 0, 0, 14);
    queue_cmd(MODE_WAIT, 1, 32'h2, 1, 0, 0, 15);
    queue_cmd(MODE_SET, 0, 32'h0000_0013, 0, 0, 0, 0);
    queue_cmd(MODE_CLEAR, 1, 32'h0, 0, 0, 0, 0);
    queue_cmd(MODE_DELETE, 1, 0, 0, 0, 0, 0);
    queue_cmd(MODE_DELETE, 1, 0, 0, 0, 0, 0);
    repeat (17) queue_cmd(MODE_WAIT, 0, 32'h4000_0000, 1, 0, 0, $urandom);
    queue_cmd(MODE_SET, 0, 32'hffff_ffff, 0, 0, 0, 0);
    repeat (64) queue_cmd(MODE_CREATE, 0, 32'h5, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) queue_cmd(MODE_DELETE, i, 0, 0, 0, 0, 0);
    wait (cmd_queue.size() == 0 && !start);
    wait (rsp_expected.size() == 0);

    send_idle_pct = 16;
    run_random(38);
    send_idle_pct = 62;
    run_random(38);
    send_idle_pct = 0;
    run_random(38);

    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && rsp_expected.size() == 0) begin
      $display("event_flag_unit_tb: PASS");
    end else begin
      $display("event_flag_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
